FILE: src/isac_pkg.sv
// Package for the interval splitter: item types, queue entry type, codes and the time key.
// Used by every module of the block but the cut table RAM; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package isac_pkg;

  localparam int TIME_W        = 32;
  localparam int ROW_W         = 32;
  localparam int SLOT_W        = 4;
  localparam int COUNT_W       = 5;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int DEF_MAX_CUTS  = 16;
  localparam int DEF_TIME_BITS = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SPLIT = 1'b1;

  localparam logic REG_CUT_COUNT = 1'b0;

  typedef struct packed {
    logic                     opcode;
    logic [SLOT_W-1:0]        cut_slot;
    logic signed [TIME_W-1:0] cut_value;
    logic signed [TIME_W-1:0] interval_start;
    logic signed [TIME_W-1:0] interval_stop;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row_index;
    logic signed [TIME_W-1:0] piece_start;
    logic signed [TIME_W-1:0] piece_end;
    logic                     censored;
    logic                     last_piece;
  } out_item_t;

  typedef struct packed {
    logic                split;
    logic                slot_ok;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   cut_value;
    logic [TIME_W-1:0]   start;
    logic [TIME_W-1:0]   stop;
    logic [TIME_W-1:0]   key_start;
    logic [TIME_W-1:0]   key_stop;
    logic [ROW_W-1:0]    row;
  } cmd_t;

  // Sign-extends the low tw bits and flips the top bit, so that an unsigned
  // compare of two keys gives the signed order of the times.
  function automatic logic [TIME_W-1:0] time_key(input logic [TIME_W-1:0] v, input int tw);
    logic [TIME_W-1:0] ext;
    int                b;
    for (b = 0; b < TIME_W; b++) begin
      ext[b] = (b < tw) ? v[b] : v[tw-1];
    end
    return ext ^ {1'b1, {(TIME_W-1){1'b0}}};
  endfunction

endpackage

`default_nettype wire

FILE: src/isac_cut_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Holds the cut table; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module isac_cut_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/isac_front.sv
// Front part: accepts input items, classifies them, numbers the intervals
// and holds them in a two-entry queue. Depends on isac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isac_front #(
  parameter int MAX_CUTS  = isac_pkg::DEF_MAX_CUTS,
  parameter int TIME_BITS = isac_pkg::DEF_TIME_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire isac_pkg::in_item_t in_data,
  output logic                   q_valid,
  output isac_pkg::cmd_t         q_entry,
  input  wire logic              q_pop
);
  import isac_pkg::*;

  localparam int TW = (TIME_BITS > TIME_W) ? TIME_W : TIME_BITS;

  cmd_t             cmd;
  cmd_t             q_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             push;
  logic             pop;

  always_comb begin
    cmd.split     = (in_data.opcode == OP_SPLIT);
    cmd.slot_ok   = ({2'b00, in_data.cut_slot} < 6'(MAX_CUTS));
    cmd.slot      = in_data.cut_slot;
    cmd.cut_value = in_data.cut_value;
    cmd.start     = in_data.interval_start;
    cmd.stop      = in_data.interval_stop;
    cmd.key_start = time_key(in_data.interval_start, TW);
    cmd.key_stop  = time_key(in_data.interval_stop, TW);
    cmd.row       = row_r;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_entry  = q_r[rp_r];
  assign pop      = q_pop && q_valid;

  always_comb begin
    row_nxt = (push && cmd.split) ? row_r + 1'b1 : row_r;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
      row_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

FILE: src/isac_back.sv
// Back part: carries out queued items, writes cut entries and walks the cut table for a
// split, one entry a cycle unless stalled, to the output register. Depends on isac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isac_back #(
  parameter int MAX_CUTS  = isac_pkg::DEF_MAX_CUTS,
  parameter int TIME_BITS = isac_pkg::DEF_TIME_BITS,
  localparam int AW       = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [isac_pkg::COUNT_W-1:0]  cut_count,
  input  wire logic                          q_valid,
  input  wire isac_pkg::cmd_t                q_entry,
  output logic                               q_pop,
  output logic                               ram_we,
  output logic [AW-1:0]                      ram_waddr,
  output logic [isac_pkg::TIME_W-1:0]        ram_wdata,
  output logic                               ram_re,
  output logic [AW-1:0]                      ram_raddr,
  input  wire logic [isac_pkg::TIME_W-1:0]   ram_rdata,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output isac_pkg::out_item_t                out_data
);
  import isac_pkg::*;

  localparam int   TW    = (TIME_BITS > TIME_W) ? TIME_W : TIME_BITS;
  localparam int   CNT_W = $clog2(MAX_CUTS + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              dv_r, dv_nxt;
  logic [TIME_W-1:0] ps_r, ps_nxt;
  logic [TIME_W-1:0] stop_r, stop_nxt;
  logic [TIME_W-1:0] ks_r, ks_nxt;
  logic [TIME_W-1:0] ke_r, ke_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         od_r, od_nxt;

  logic              can_load;
  logic [TIME_W-1:0] kc;
  logic              qual;
  logic              consume;
  logic              more;
  logic              issue;
  logic [5:0]        n_lim;

  assign can_load = !ov_r || !out_stall;
  assign kc       = time_key(ram_rdata, TW);
  assign qual     = (kc > ks_r) && (kc < ke_r);
  assign consume  = dv_r && (!qual || can_load);
  assign more     = (j_r < n_r);
  assign issue    = (state_r == ST_RUN) && (!dv_r || consume) && more;
  assign n_lim    = ({1'b0, cut_count} > 6'(MAX_CUTS)) ? 6'(MAX_CUTS) : {1'b0, cut_count};

  assign ram_re    = issue;
  assign ram_raddr = AW'(j_r);
  assign ram_we    = (state_r == ST_IDLE) && q_valid && !q_entry.split && q_entry.slot_ok;
  assign ram_waddr = AW'(q_entry.slot);
  assign ram_wdata = q_entry.cut_value;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    dv_nxt    = dv_r;
    ps_nxt    = ps_r;
    stop_nxt  = stop_r;
    ks_nxt    = ks_r;
    ke_nxt    = ke_r;
    row_nxt   = row_r;
    ov_nxt    = out_stall ? ov_r : 1'b0;
    od_nxt    = od_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_entry.split) begin
          state_nxt = ST_RUN;
          j_nxt     = '0;
          n_nxt     = CNT_W'(n_lim);
          dv_nxt    = 1'b0;
          ps_nxt    = q_entry.start;
          stop_nxt  = q_entry.stop;
          ks_nxt    = q_entry.key_start;
          ke_nxt    = q_entry.key_stop;
          row_nxt   = q_entry.row;
        end
      end
      ST_RUN: begin
        if (issue) begin
          j_nxt  = j_r + 1'b1;
          dv_nxt = 1'b1;
        end else if (consume) begin
          dv_nxt = 1'b0;
        end
        if (dv_r && qual && can_load) begin
          ov_nxt             = 1'b1;
          od_nxt.row_index   = row_r;
          od_nxt.piece_start = ps_r;
          od_nxt.piece_end   = ram_rdata;
          od_nxt.censored    = 1'b1;
          od_nxt.last_piece  = 1'b0;
          ps_nxt             = ram_rdata;
        end else if (!dv_r && !more && can_load) begin
          ov_nxt             = 1'b1;
          od_nxt.row_index   = row_r;
          od_nxt.piece_start = ps_r;
          od_nxt.piece_end   = stop_r;
          od_nxt.censored    = 1'b0;
          od_nxt.last_piece  = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dv_r    <= 1'b0;
      ov_r    <= 1'b0;
      j_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
      ov_r    <= ov_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ps_r   <= ps_nxt;
    stop_r <= stop_nxt;
    ks_r   <= ks_nxt;
    ke_r   <= ke_nxt;
    row_r  <= row_nxt;
    od_r   <= od_nxt;
  end

endmodule

`default_nettype wire

FILE: src/interval_split_at_cutpoints.sv
// Top level of the interval splitter: configuration register, front part,
// queue, cut table RAM and back part. Depends on isac_pkg and all isac_ modules.
//
// An item with opcode load writes one cut table entry; an item with opcode
// split turns the interval (start, stop] into one censored piece for every
// cut in use that lies strictly inside it, in table order, and then one
// uncensored last piece that ends at the stop. The front part buffers up to two
// items, so input can keep flowing while the back part works. The back part
// writes a load while idle; on a split it reads one table entry a cycle from
// the registered read port of the cut table RAM, unless a stall on the result
// channel holds a piece back. The entries must be loaded in ascending order
// before cut_count covers them.
`timescale 1ns / 1ps
`default_nettype none

module interval_split_at_cutpoints #(
  parameter int MAX_CUTS  = isac_pkg::DEF_MAX_CUTS,
  parameter int TIME_BITS = isac_pkg::DEF_TIME_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire isac_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output isac_pkg::out_item_t                   out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [isac_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [isac_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [isac_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import isac_pkg::*;

  localparam int AW = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;

  logic [COUNT_W-1:0] cut_count_r, cut_count_nxt;
  logic               cfg_wr;
  logic               reg_sel;

  logic               q_valid;
  cmd_t               q_entry;
  logic               q_pop;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [TIME_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [TIME_W-1:0]  ram_rdata;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cut_count_nxt = cut_count_r;
    if (cfg_wr && (reg_sel == REG_CUT_COUNT)) begin
      cut_count_nxt = pwdata[COUNT_W-1:0];
    end
    prdata = '0;
    if (reg_sel == REG_CUT_COUNT) begin
      prdata = {{(CFG_DATA_W-COUNT_W){1'b0}}, cut_count_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_count_r <= '0;
    end else begin
      cut_count_r <= cut_count_nxt;
    end
  end

  isac_front #(
    .MAX_CUTS  (MAX_CUTS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  isac_cut_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_CUTS)
  ) u_cut_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  isac_back #(
    .MAX_CUTS  (MAX_CUTS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cut_count (cut_count_r),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/isac_split_checker.sv
// Checker for the interval splitter: watches the item channels and the APB port,
// predicts the pieces of every accepted item and compares them in order.
// Depends on isac_pkg for the item types, codes and widths.
`timescale 1ns / 1ps

module isac_split_checker import isac_pkg::*; #(
  parameter int MAX_CUTS = DEF_MAX_CUTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pieces_open,
  output int                    pieces_checked
);

  localparam logic [CFG_ADDR_W-1:0] CUT_COUNT_ADDR = {REG_CUT_COUNT, 2'b00};
  localparam int SHOW_LIMIT = 40;

  logic signed [TIME_W-1:0] cut_times [MAX_CUTS] = '{default: '0};
  logic [ROW_W-1:0]         next_row = '0;
  logic [COUNT_W-1:0]       cuts_in_use = '0;
  out_item_t                pieces_due [$];
  int                       fails = 0;
  int                       checked = 0;
  int                       shown = 0;

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    fails++;
    if (shown < SHOW_LIMIT) begin
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
    end
    shown++;
  endtask

  function automatic void predict_pieces(input in_item_t it);
    int                       n;
    int                       j;
    logic signed [TIME_W-1:0] lo;
    logic signed [TIME_W-1:0] hi;
    logic signed [TIME_W-1:0] from;
    logic signed [TIME_W-1:0] c;
    out_item_t                p;
    if (it.opcode == OP_LOAD) begin
      if (int'(it.cut_slot) < MAX_CUTS) cut_times[it.cut_slot] = it.cut_value;
      return;
    end
    n = (int'(cuts_in_use) > MAX_CUTS) ? MAX_CUTS : int'(cuts_in_use);
    lo = it.interval_start;
    hi = it.interval_stop;
    from = lo;
    p.row_index = next_row;
    next_row++;
    for (j = 0; j < n; j++) begin
      c = cut_times[j];
      if (c > lo && c < hi) begin
        p.piece_start = from;
        p.piece_end = c;
        p.censored = 1'b1;
        p.last_piece = 1'b0;
        pieces_due.push_back(p);
        from = c;
      end
    end
    p.piece_start = from;
    p.piece_end = hi;
    p.censored = 1'b0;
    p.last_piece = 1'b1;
    pieces_due.push_back(p);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      next_row = '0;
      cuts_in_use = '0;
      pieces_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == CUT_COUNT_ADDR) begin
        cuts_in_use = pwdata[COUNT_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (pieces_due.size() == 0) begin
          fails++;
          if (shown < SHOW_LIMIT) begin
            $display("%0t: piece with nothing expected, actual row 0x%h end 0x%h",
                     $time, out_data.row_index, out_data.piece_end);
          end
          shown++;
        end else begin
          want = pieces_due.pop_front();
          checked++;
          if (out_data.row_index !== want.row_index)
            flag_field("row_index", want.row_index, out_data.row_index);
          if (out_data.piece_start !== want.piece_start)
            flag_field("piece_start", want.piece_start, out_data.piece_start);
          if (out_data.piece_end !== want.piece_end)
            flag_field("piece_end", want.piece_end, out_data.piece_end);
          if (out_data.censored !== want.censored)
            flag_field("censored", want.censored, out_data.censored);
          if (out_data.last_piece !== want.last_piece)
            flag_field("last_piece", want.last_piece, out_data.last_piece);
        end
      end
      if (in_valid && !in_stall) predict_pieces(in_data);
    end
    fail_count <= fails;
    pieces_open <= pieces_due.size();
    pieces_checked <= checked;
  end

endmodule

FILE: tb/interval_split_at_cutpoints_tb.sv
// Testbench top for the interval splitter: clock, reset, load and split items,
// cut_count writes over APB, random gaps on both channels and the verdict.
// Depends on isac_pkg, interval_split_at_cutpoints and isac_split_checker.
`timescale 1ns / 1ps

module interval_split_at_cutpoints_tb;
  import isac_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CUT_COUNT_ADDR = {REG_CUT_COUNT, 2'b00};
  localparam int ITEM_TARGET   = 430;
  localparam int PHASE_ITEMS   = 36;
  localparam int SETTLE_CYCLES = 40;
  localparam int COUNT_PLAN [8] = '{31, 0, 1, 17, 16, 2, 15, 8};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pieces_open;
  int pieces_checked;
  int loads_sent = 0;
  int splits_sent = 0;
  int settings_used = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  logic signed [TIME_W-1:0] plan_cuts [DEF_MAX_CUTS] = '{default: '0};

  interval_split_at_cutpoints dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  isac_split_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pieces_open(pieces_open),
    .pieces_checked(pieces_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_len();
    return ($urandom_range(0, 99) < 92) ? $urandom_range(0, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic signed [TIME_W-1:0] near_cut();
    if ($urandom_range(0, 99) < 15) return $urandom;
    return plan_cuts[$urandom_range(0, DEF_MAX_CUTS-1)] + $urandom_range(0, 6) - 3;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (calm) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(0, 2) == 0);
      stall_left = idle_len();
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    if (it.opcode == OP_LOAD) begin
      loads_sent++;
      plan_cuts[it.cut_slot] = it.cut_value;
    end else begin
      splits_sent++;
    end
    gap = (calm || $urandom_range(0, 1) == 1) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_load(input int slot, input logic signed [TIME_W-1:0] value);
    in_item_t it;
    it.opcode = OP_LOAD;
    it.cut_slot = slot[SLOT_W-1:0];
    it.cut_value = value;
    it.interval_start = $urandom;
    it.interval_stop = $urandom;
    send_item(it);
  endtask

  task automatic send_split(input logic signed [TIME_W-1:0] start,
                            input logic signed [TIME_W-1:0] stop);
    in_item_t it;
    it.opcode = OP_SPLIT;
    it.cut_slot = SLOT_W'($urandom_range(0, 15));
    it.cut_value = $urandom;
    it.interval_start = start;
    it.interval_stop = stop;
    send_item(it);
  endtask

  task automatic send_random_split();
    logic signed [TIME_W-1:0] a;
    logic signed [TIME_W-1:0] b;
    int                       r;
    a = near_cut();
    b = near_cut();
    r = $urandom_range(0, 99);
    if (r < 75 && b < a) send_split(b, a);
    else if (r >= 75 && r < 80) send_split(a, a);
    else send_split(a, b);
  endtask

  task automatic reload_table();
    logic signed [TIME_W-1:0] base;
    int                       step;
    int                       i;
    base = $urandom;
    step = $urandom_range(1, 2000);
    if ($urandom_range(0, 3) == 0) begin
      for (i = 0; i < DEF_MAX_CUTS; i++) send_load(i, $urandom);
    end else begin
      for (i = 0; i < DEF_MAX_CUTS; i++) send_load(i, base + i * step);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pieces_open != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cut_count(input int value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CUT_COUNT_ADDR;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    settings_used++;
  endtask

  initial begin
    int phase;
    int i;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // With no cuts in use every interval comes back whole.
    send_split(-5, 5);
    send_load(0, 32'sh8000_0000);
    for (i = 1; i < DEF_MAX_CUTS - 1; i++) send_load(i, -700 + 100 * i);
    send_load(DEF_MAX_CUTS - 1, 32'sh7FFF_FFFF);
    settle();
    write_cut_count(DEF_MAX_CUTS);
    send_split(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_split(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_split(0, 0);
    send_split(-150, 300);
    send_split(-600, -599);
    // An out-of-order entry makes the piece starts run backward.
    send_load(5, 650);
    send_split(-700, 1000);

    phase = 0;
    while (loads_sent + splits_sent < ITEM_TARGET) begin
      settle();
      write_cut_count(phase < 8 ? COUNT_PLAN[phase] : $urandom_range(0, 31));
      calm = (phase % 4 == 3);
      if (phase == 0 || $urandom_range(0, 9) < 4) reload_table();
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 12) send_load($urandom_range(0, 15), near_cut());
        else send_random_split();
      end
      phase++;
    end
    calm = 1'b0;
    settle();

    $display("Sent %0d load items and %0d split items under %0d cut_count settings.",
             loads_sent, splits_sent, settings_used);
    $display("Compared %0d pieces against the prediction.", pieces_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Run timed out with %0d pieces still expected.", pieces_open);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
